FILE: src/cet_pkg.sv
// Shared types and constants for the calculator expression tokenizer.
// Character codes, token kind codes, lexer mode codes and status structs.
// No dependencies.
package cet_pkg;

	// Lexer modes
	localparam logic [2:0] MODE_IDLE     = 3'd0;
	localparam logic [2:0] MODE_NUMBER   = 3'd1;
	localparam logic [2:0] MODE_NAME     = 3'd2;
	localparam logic [2:0] MODE_ARG_LEAD = 3'd3;
	localparam logic [2:0] MODE_ARG_BODY = 3'd4;

	// ASCII codes
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_CR      = 8'd13;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_LPAREN  = 8'd40;
	localparam logic [7:0] CH_RPAREN  = 8'd41;
	localparam logic [7:0] CH_STAR    = 8'd42;
	localparam logic [7:0] CH_PLUS    = 8'd43;
	localparam logic [7:0] CH_MINUS   = 8'd45;
	localparam logic [7:0] CH_POINT   = 8'd46;
	localparam logic [7:0] CH_SLASH   = 8'd47;
	localparam logic [7:0] CH_ZERO    = 8'd48;
	localparam logic [7:0] CH_NINE    = 8'd57;
	localparam logic [7:0] CH_EQUAL   = 8'd61;
	localparam logic [7:0] CH_UPPER_A = 8'd65;
	localparam logic [7:0] CH_UPPER_Z = 8'd90;
	localparam logic [7:0] CH_CARET   = 8'd94;
	localparam logic [7:0] CH_LOWER_A = 8'd97;
	localparam logic [7:0] CH_LOWER_C = 8'd99;
	localparam logic [7:0] CH_LOWER_L = 8'd108;
	localparam logic [7:0] CH_LOWER_N = 8'd110;
	localparam logic [7:0] CH_LOWER_S = 8'd115;
	localparam logic [7:0] CH_LOWER_T = 8'd116;
	localparam logic [7:0] CH_LOWER_Z = 8'd122;

	// Token kinds
	localparam logic [4:0] TK_NUM    = 5'd0;
	localparam logic [4:0] TK_PLUS   = 5'd1;
	localparam logic [4:0] TK_MINUS  = 5'd2;
	localparam logic [4:0] TK_DIV    = 5'd3;
	localparam logic [4:0] TK_MUL    = 5'd4;
	localparam logic [4:0] TK_LPAREN = 5'd5;
	localparam logic [4:0] TK_RPAREN = 5'd6;
	localparam logic [4:0] TK_POW    = 5'd7;
	localparam logic [4:0] TK_EQ     = 5'd8;
	localparam logic [4:0] TK_SIN    = 5'd9;
	localparam logic [4:0] TK_COS    = 5'd10;
	localparam logic [4:0] TK_TAN    = 5'd11;
	localparam logic [4:0] TK_SINH   = 5'd12;
	localparam logic [4:0] TK_COSH   = 5'd13;
	localparam logic [4:0] TK_TANH   = 5'd14;
	localparam logic [4:0] TK_ASIN   = 5'd15;
	localparam logic [4:0] TK_ACOS   = 5'd16;
	localparam logic [4:0] TK_ATAN   = 5'd17;
	localparam logic [4:0] TK_ASINH  = 5'd18;
	localparam logic [4:0] TK_ACOSH  = 5'd19;
	localparam logic [4:0] TK_ATANH  = 5'd20;
	localparam logic [4:0] TK_LN     = 5'd21;
	localparam logic [4:0] TK_LOG    = 5'd22;
	localparam logic [4:0] TK_VAR    = 5'd23;

	localparam logic [3:0] FRAC_MAX = 4'd15;

	// One output word
	typedef struct packed {
		logic [4:0]  kind;
		logic [4:0]  letter;
		logic        neg;
		logic [31:0] mant;
		logic [3:0]  frac;
		logic        sat;
		logic        last;
		logic        done;
	} token_t;

	// Lexer status toward the top level
	typedef struct packed {
		logic [2:0] mode;
		logic [1:0] ntok;
	} lex_stat_t;

	// Token queue status
	typedef struct packed {
		logic [1:0] free;
		logic [1:0] count;
	} q_stat_t;

endpackage

FILE: src/calculator_expression_tokenizer.sv
// Top level of the calculator expression tokenizer: input stage, lexer step
// and token queue. Depends on cet_pkg, cet_lexer and cet_tokq.
//
// Usage: characters enter on in_valid/in_stall (char_code, end_of_expr set
// on the final character). Tokens leave on out_valid/out_stall, one word
// per token; run_last marks the last word a character caused and expr_done
// marks the last word of the character that closed the expression.
// A character may cause zero, one or two words.
// Path: a taken character is registered in the input stage, and its words
// are written into the token queue when its step commits; the queue offers
// them from there, and the second word of a pair follows the first.
// Throughput: one character per cycle while each makes at most one word and
// the receiver does not stall; a character that makes two words can stall
// the input, since the two-entry token queue has a single output port.
// Reset returns the lexer to idle with no pending number or name and
// empties the queue. When the receiver stalls, the queue holds its words,
// and once it cannot take the next step's words the input stage holds its
// character and in_stall rises.
module calculator_expression_tokenizer #(
	parameter int MANTISSA_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_expr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  token_kind,
	output logic [4:0]  var_letter,
	output logic        is_negative,
	output logic [31:0] mantissa,
	output logic [3:0]  fraction_digits,
	output logic        saturated,
	output logic        run_last,
	output logic        expr_done
);

	logic [7:0] char_s1;
	logic       end_s1;
	logic       valid_s1;
	logic       commit;
	logic       pop;
	logic       load;

	cet_pkg::token_t    tok0, tok1, rd_tok;
	cet_pkg::lex_stat_t lex_stat;
	cet_pkg::q_stat_t   q_stat;

	// Commit the staged character when the queue has room for its words
	assign commit   = valid_s1 && (lex_stat.ntok <= q_stat.free);
	assign in_stall = valid_s1 && !commit;
	assign load     = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;

	// Input stage: load a character, hold it while stalled
	always_ff @(posedge clk) begin
		if (load) begin
			char_s1 <= char_code;
			end_s1  <= end_of_expr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= load || (valid_s1 && !commit);
		end
	end

	cet_lexer #(
		.MANTISSA_BITS(MANTISSA_BITS)
	) u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_code  (char_s1),
		.end_of_expr(end_s1),
		.commit     (commit),
		.tok0       (tok0),
		.tok1       (tok1),
		.stat       (lex_stat)
	);

	cet_tokq u_tokq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (commit),
		.wr_cnt  (lex_stat.ntok),
		.wr0     (tok0),
		.wr1     (tok1),
		.rd      (pop),
		.rd_valid(out_valid),
		.rd_tok  (rd_tok),
		.stat    (q_stat)
	);

	assign token_kind      = rd_tok.kind;
	assign var_letter      = rd_tok.letter;
	assign is_negative     = rd_tok.neg;
	assign mantissa        = rd_tok.mant;
	assign fraction_digits = rd_tok.frac;
	assign saturated       = rd_tok.sat;
	assign run_last        = rd_tok.last;
	assign expr_done       = rd_tok.done;

	// The lexer is back at idle after the closing character of an expression
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		commit && end_s1 |=> lex_stat.mode == cet_pkg::MODE_IDLE)
		else $error("lexer not idle after end of expression");

	// A word that closes the expression is the last of its step
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expr_done |-> run_last)
		else $error("expr_done without run_last");

	// With a held word at the output, a two-word step never commits
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !(commit && lex_stat.ntok == 2'd2))
		else $error("token queue overfilled");

	// Queue occupancy stays within its two entries
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count != 2'd3)
		else $error("token queue count out of range");

endmodule

FILE: src/cet_lexer.sv
// Lexer step for the calculator expression tokenizer: state registers and
// the per-character next-state and token logic (up to two tokens a step).
// Depends on cet_pkg.
module cet_lexer #(
	parameter int MANTISSA_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         char_code,
	input  logic               end_of_expr,
	input  logic               commit,
	output cet_pkg::token_t    tok0,
	output cet_pkg::token_t    tok1,
	output cet_pkg::lex_stat_t stat
);

	localparam int MW = (MANTISSA_BITS > 32) ? 32 : MANTISSA_BITS;
	localparam int SW = MW + 4;

	typedef struct packed {
		logic [2:0]    mode;
		logic [2:0]    len;
		logic [7:0]    first;
		logic [7:0]    second;
		logic [7:0]    fourth;
		logic [MW-1:0] num;
		logic [3:0]    frac;
		logic          point;
		logic          sign;
		logic          stopped;
		logic          ovf;
	} lex_state_t;

	lex_state_t st_q;
	lex_state_t s;
	cet_pkg::token_t tok_a, tok_i, tok_e;
	logic va, vi, ve, redo;
	logic [4:0] k;
	logic [1:0] ntok;

	function automatic logic is_digit(logic [7:0] c);
		return c inside {[cet_pkg::CH_ZERO:cet_pkg::CH_NINE]};
	endfunction

	// Multiply by ten and add one digit, clamping at the mantissa limit
	function automatic lex_state_t add_digit(lex_state_t si, logic [7:0] c);
		lex_state_t so;
		logic [SW-1:0] sum;
		so  = si;
		sum = SW'({si.num, 3'b000}) + SW'({si.num, 1'b0}) + SW'(c[3:0]);
		if (sum[SW-1:MW] != '0) begin
			so.num = '1;
			so.ovf = 1'b1;
		end else begin
			so.num = sum[MW-1:0];
		end
		return so;
	endfunction

	function automatic lex_state_t clear_num(lex_state_t si);
		lex_state_t so;
		so         = si;
		so.num     = '0;
		so.frac    = '0;
		so.point   = 1'b0;
		so.sign    = 1'b0;
		so.stopped = 1'b0;
		so.ovf     = 1'b0;
		return so;
	endfunction

	// One character of an argument body, atof style
	function automatic lex_state_t arg_char(lex_state_t si, logic [7:0] c);
		lex_state_t so;
		so = si;
		if (!si.stopped) begin
			if (is_digit(c)) begin
				if (!si.point) begin
					so = add_digit(si, c);
				end else if (si.frac >= cet_pkg::FRAC_MAX) begin
					so.ovf = 1'b1;
				end else begin
					so      = add_digit(si, c);
					so.frac = si.frac + 4'd1;
				end
			end else if (c == cet_pkg::CH_POINT && !si.point) begin
				so.point = 1'b1;
			end else begin
				so.stopped = 1'b1;
			end
		end
		return so;
	endfunction

	// Function kind from the first letter, length and second or fourth letter of the name; TK_NUM marks no match
	function automatic logic [4:0] func_kind(lex_state_t si);
		logic [4:0] r;
		logic three, six;
		three = (si.len == 3'd3);
		six   = (si.len == 3'd6);
		case (si.first)
			cet_pkg::CH_LOWER_S: r = three ? cet_pkg::TK_SIN : cet_pkg::TK_SINH;
			cet_pkg::CH_LOWER_C: r = three ? cet_pkg::TK_COS : cet_pkg::TK_COSH;
			cet_pkg::CH_LOWER_T: r = three ? cet_pkg::TK_TAN : cet_pkg::TK_TANH;
			cet_pkg::CH_LOWER_A: begin
				case (si.fourth)
					cet_pkg::CH_LOWER_S: r = six ? cet_pkg::TK_ASIN : cet_pkg::TK_ASINH;
					cet_pkg::CH_LOWER_C: r = six ? cet_pkg::TK_ACOS : cet_pkg::TK_ACOSH;
					cet_pkg::CH_LOWER_T: r = six ? cet_pkg::TK_ATAN : cet_pkg::TK_ATANH;
					default:             r = cet_pkg::TK_NUM;
				endcase
			end
			cet_pkg::CH_LOWER_L: begin
				r = (si.second == cet_pkg::CH_LOWER_N) ? cet_pkg::TK_LN : cet_pkg::TK_LOG;
			end
			default: r = cet_pkg::TK_NUM;
		endcase
		return r;
	endfunction

	// Operator kind; TK_NUM when the character is no operator
	function automatic logic [4:0] op_kind(logic [7:0] c);
		logic [4:0] r;
		case (c)
			cet_pkg::CH_PLUS:   r = cet_pkg::TK_PLUS;
			cet_pkg::CH_MINUS:  r = cet_pkg::TK_MINUS;
			cet_pkg::CH_SLASH:  r = cet_pkg::TK_DIV;
			cet_pkg::CH_STAR:   r = cet_pkg::TK_MUL;
			cet_pkg::CH_LPAREN: r = cet_pkg::TK_LPAREN;
			cet_pkg::CH_RPAREN: r = cet_pkg::TK_RPAREN;
			cet_pkg::CH_CARET:  r = cet_pkg::TK_POW;
			cet_pkg::CH_EQUAL:  r = cet_pkg::TK_EQ;
			default:            r = cet_pkg::TK_NUM;
		endcase
		return r;
	endfunction

	function automatic cet_pkg::token_t make_tok(logic [4:0] kind, logic [4:0] letter,
			logic neg, logic [MW-1:0] mant, logic [3:0] frac, logic sat);
		cet_pkg::token_t t;
		t.kind   = kind;
		t.letter = letter;
		t.neg    = neg;
		t.mant   = 32'(mant);
		t.frac   = frac;
		t.sat    = sat;
		t.last   = 1'b0;
		t.done   = 1'b0;
		return t;
	endfunction

	// Next state and candidate tokens for the character in the stage
	always_comb begin
		s     = st_q;
		redo  = 1'b0;
		tok_a = '0;
		tok_i = '0;
		tok_e = '0;
		va    = 1'b0;
		vi    = 1'b0;
		ve    = 1'b0;
		k     = cet_pkg::TK_NUM;

		case (st_q.mode)
			cet_pkg::MODE_NUMBER: begin
				if (is_digit(char_code)) begin
					s = add_digit(s, char_code);
				end else begin
					tok_a  = make_tok(cet_pkg::TK_NUM, 5'd0, 1'b0, s.num, 4'd0, s.ovf);
					va     = 1'b1;
					s      = clear_num(s);
					s.mode = cet_pkg::MODE_IDLE;
					redo   = 1'b1;
				end
			end
			cet_pkg::MODE_NAME: begin
				if (char_code == cet_pkg::CH_LPAREN) begin
					s      = clear_num(s);
					s.mode = cet_pkg::MODE_ARG_LEAD;
				end else if (char_code inside {[cet_pkg::CH_LOWER_A:cet_pkg::CH_LOWER_Z]}) begin
					if (st_q.len == 3'd1) s.second = char_code;
					if (st_q.len == 3'd3) s.fourth = char_code;
					if (st_q.len < 3'd7) s.len = st_q.len + 3'd1;
				end else begin
					s.mode = cet_pkg::MODE_IDLE;
					redo   = 1'b1;
				end
			end
			cet_pkg::MODE_ARG_LEAD, cet_pkg::MODE_ARG_BODY: begin
				if (char_code == cet_pkg::CH_RPAREN) begin
					k = func_kind(s);
					if (k != cet_pkg::TK_NUM) begin
						tok_a = make_tok(k, 5'd0, s.sign, s.num, s.frac, s.ovf);
						va    = 1'b1;
					end
					s      = clear_num(s);
					s.mode = cet_pkg::MODE_IDLE;
				end else if (st_q.mode == cet_pkg::MODE_ARG_BODY) begin
					s = arg_char(s, char_code);
				end else if (char_code == cet_pkg::CH_SPACE ||
						char_code inside {[cet_pkg::CH_TAB:cet_pkg::CH_CR]}) begin
					s.mode = cet_pkg::MODE_ARG_LEAD;
				end else if (char_code == cet_pkg::CH_PLUS) begin
					s.mode = cet_pkg::MODE_ARG_BODY;
				end else if (char_code == cet_pkg::CH_MINUS) begin
					s.sign = 1'b1;
					s.mode = cet_pkg::MODE_ARG_BODY;
				end else begin
					s.mode = cet_pkg::MODE_ARG_BODY;
					s      = arg_char(s, char_code);
				end
			end
			default: begin
				s.mode = cet_pkg::MODE_IDLE;
				redo   = 1'b1;
			end
		endcase

		// Handle the character afresh from idle
		if (redo) begin
			if (is_digit(char_code)) begin
				s      = clear_num(s);
				s.mode = cet_pkg::MODE_NUMBER;
				s      = add_digit(s, char_code);
			end else if (op_kind(char_code) != cet_pkg::TK_NUM) begin
				tok_i = make_tok(op_kind(char_code), 5'd0, 1'b0, '0, 4'd0, 1'b0);
				vi    = 1'b1;
			end else if (char_code inside {[cet_pkg::CH_UPPER_A:cet_pkg::CH_UPPER_Z]}) begin
				tok_i = make_tok(cet_pkg::TK_VAR, 5'(char_code - cet_pkg::CH_UPPER_A),
					1'b0, '0, 4'd0, 1'b0);
				vi    = 1'b1;
			end else if (char_code inside {cet_pkg::CH_LOWER_A, cet_pkg::CH_LOWER_S,
					cet_pkg::CH_LOWER_C, cet_pkg::CH_LOWER_T, cet_pkg::CH_LOWER_L}) begin
				s.mode   = cet_pkg::MODE_NAME;
				s.first  = char_code;
				s.second = 8'd0;
				s.fourth = 8'd0;
				s.len    = 3'd1;
			end
		end

		// Flush what is pending at end of expression, then return to reset
		if (end_of_expr) begin
			if (s.mode == cet_pkg::MODE_NUMBER) begin
				tok_e = make_tok(cet_pkg::TK_NUM, 5'd0, 1'b0, s.num, 4'd0, s.ovf);
				ve    = 1'b1;
			end else if (s.mode == cet_pkg::MODE_ARG_LEAD ||
					s.mode == cet_pkg::MODE_ARG_BODY) begin
				k = func_kind(s);
				if (k != cet_pkg::TK_NUM) begin
					tok_e = make_tok(k, 5'd0, s.sign, s.num, s.frac, s.ovf);
					ve    = 1'b1;
				end
			end
			s = '0;
		end
	end

	// Pack candidates in order and mark the last word of the step
	always_comb begin
		tok1 = '0;
		if (va) begin
			tok0 = tok_a;
			tok1 = vi ? tok_i : tok_e;
		end else if (vi) begin
			tok0 = tok_i;
			tok1 = tok_e;
		end else begin
			tok0 = tok_e;
		end
		ntok = 2'({1'b0, va} + {1'b0, vi} + {1'b0, ve});
		if (ntok == 2'd2) begin
			tok1.last = 1'b1;
			tok1.done = end_of_expr;
		end else begin
			tok0.last = 1'b1;
			tok0.done = end_of_expr;
		end
	end

	assign stat.mode = st_q.mode;
	assign stat.ntok = ntok;

	// Advance the lexer state when the step commits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (commit) begin
			st_q <= s;
		end
	end

endmodule

FILE: src/cet_tokq.sv
// Two-entry token queue between the lexer step and the output channel.
// Takes up to two words a cycle, gives one. Depends on cet_pkg.
module cet_tokq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [1:0]       wr_cnt,
	input  cet_pkg::token_t  wr0,
	input  cet_pkg::token_t  wr1,
	input  logic             rd,
	output logic             rd_valid,
	output cet_pkg::token_t  rd_tok,
	output cet_pkg::q_stat_t stat
);

	cet_pkg::token_t q_q [2];
	logic       head_q;
	logic [1:0] count_q;
	logic       tail;
	logic [1:0] push_n;

	assign tail     = head_q ^ count_q[0];
	assign push_n   = wr ? wr_cnt : 2'd0;
	assign rd_valid = (count_q != 2'd0);
	assign rd_tok   = q_q[head_q];

	// Room for this cycle, counting the word that leaves now
	assign stat.free  = 2'(2'd2 - count_q + {1'b0, rd});
	assign stat.count = count_q;

	// Hold the words
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) q_q[tail] <= wr0;
		if (push_n == 2'd2) q_q[~tail] <= wr1;
	end

	// Advance head and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			head_q  <= head_q ^ rd;
			count_q <= 2'(count_q - {1'b0, rd} + push_n);
		end
	end

endmodule
